// File: src/bab_pkg.sv
`default_nettype none

package bab_pkg;

  // bitmap word geometry
  localparam int WORD_W = 64;
  localparam int WORD_LG = 6;

  // block number space of the block and allocated_block fields
  localparam int BLOCK_SPACE = 4096;
  localparam int MAX_BLOCKS_DEF = 4096;

  // field widths
  localparam int CMD_W = 2;
  localparam int BLK_W = 12;
  localparam int NUM_W = 13;
  localparam int RSV_W = 12;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  // register reset values
  localparam logic [NUM_W-1:0] NUM_BLOCKS_RST = 13'd4096;
  localparam logic [RSV_W-1:0] RSV_BLOCKS_RST = 12'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_OCCUPY = 2'd2,
    CMD_FORMAT = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_RMW_RD,
    S_RMW_WR,
    S_FORMAT,
    S_DONE
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  scan;
    logic  rmw_rd;
    logic  rmw_wr;
    logic  sweep_init;
    logic  sweep_fmt;
    logic  set_res;
    stat_t res_code;
    logic  out_load;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic issue_ok;
    logic chk_valid;
    logic found;
    logic in_range;
    logic sweep_last;
  } dp_flags_t;

endpackage

`default_nettype wire

// File: src/block_allocation_bitmap.sv
`default_nettype none

// First-fit free-block bitmap, one bit per block, 1 = free.
// Input channel in_valid/in_ready carries cmd and block; output channel
// out_valid/out_ready carries status and allocated_block, one beat per item.
// Configuration: cfg_wr_en with cfg_addr 0 (num_blocks) or 1 (reserved_blocks)
// and cfg_wdata, taken at any edge with cfg_wr_en high, meant for idle periods.
// The bitmap sits in a memory of 64-bit words, (MAX_BLOCKS+63)/64 deep, with
// one read and one write port; a controller sequences it one item at a time.
// Allocate streams one word per cycle through the first-fit search; it stops
// at the first free block or, with none free, after the last word in range.
// Free and occupy do a read-modify-write of one word, skipped if rejected.
// Format rewrites every word, one per cycle.
// in_ready rises in the cycle after the result is loaded.
// After reset a clearing pass writes all words free, one per cycle, with
// in_ready low; configuration writes are taken meanwhile.
// A stalled result waits in the output register while the next item runs.
module block_allocation_bitmap #(
  parameter int MAX_BLOCKS = bab_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bab_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [bab_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bab_pkg::CMD_W-1:0]      cmd,
  input  logic [bab_pkg::BLK_W-1:0]      block,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bab_pkg::STAT_W-1:0]     status,
  output logic [bab_pkg::BLK_W-1:0]      allocated_block
);
  import bab_pkg::*;

  dp_ctrl_t  ctl;
  dp_flags_t flags;

  // sequencer
  bab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .flags     (flags)
  );

  // bitmap memory and search logic
  bab_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .block           (block),
    .status          (status),
    .allocated_block (allocated_block),
    .ctl             (ctl),
    .flags           (flags)
  );

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a granted block number only comes with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && allocated_block != '0) |-> (status == STAT_OK))
    else $error("nonzero block with error status");

  // a new result beat is raised only from a busy cycle
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while idle");

  // memory writes only while an item or the clearing pass is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (ctl.scan || ctl.rmw_wr || ctl.sweep_fmt || ctl.sweep_init) |-> !in_ready)
    else $error("bitmap written while accepting input");

endmodule

`default_nettype wire

// File: src/bab_ctrl.sv
`default_nettype none

module bab_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bab_pkg::CMD_W-1:0] cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bab_pkg::dp_ctrl_t         ctl,
  input  bab_pkg::dp_flags_t        flags
);
  import bab_pkg::*;

  fsm_state_t state, state_next;
  logic       out_valid_next;

  // state and output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_INIT: begin
        ctl.sweep_init = 1'b1;
        if (flags.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          case (cmd_t'(cmd))
            CMD_ALLOC:  state_next = S_ALLOC;
            CMD_FREE:   state_next = S_RMW_RD;
            CMD_OCCUPY: state_next = S_RMW_RD;
            CMD_FORMAT: state_next = S_FORMAT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        ctl.scan = 1'b1;
        if (flags.chk_valid && flags.found) begin
          state_next = S_DONE;
        end else if (!flags.chk_valid && !flags.issue_ok) begin
          ctl.set_res  = 1'b1;
          ctl.res_code = STAT_FULL;
          state_next   = S_DONE;
        end
      end
      S_RMW_RD: begin
        if (flags.in_range) begin
          ctl.rmw_rd = 1'b1;
          state_next = S_RMW_WR;
        end else begin
          ctl.set_res  = 1'b1;
          ctl.res_code = STAT_RANGE;
          state_next   = S_DONE;
        end
      end
      S_RMW_WR: begin
        ctl.rmw_wr = 1'b1;
        state_next = S_DONE;
      end
      S_FORMAT: begin
        ctl.sweep_fmt = 1'b1;
        if (flags.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output beat pending until taken
  always_comb begin
    if (ctl.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

`default_nettype wire

// File: src/bab_dp.sv
`default_nettype none

module bab_dp #(
  parameter int MAX_BLOCKS = bab_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bab_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [bab_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [bab_pkg::CMD_W-1:0]      cmd,
  input  logic [bab_pkg::BLK_W-1:0]      block,
  output logic [bab_pkg::STAT_W-1:0]     status,
  output logic [bab_pkg::BLK_W-1:0]      allocated_block,
  input  bab_pkg::dp_ctrl_t              ctl,
  output bab_pkg::dp_flags_t             flags
);
  import bab_pkg::*;

  localparam int DEPTH = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int CW = (PW + WORD_LG > NUM_W) ? PW + WORD_LG : NUM_W;
  localparam int CAP = (MAX_BLOCKS < BLOCK_SPACE) ? MAX_BLOCKS : BLOCK_SPACE;

  // bits of a word that lie below block n, for a word starting at base
  function automatic logic [WORD_W-1:0] low_mask(input logic [CW-1:0] n,
                                                 input logic [CW-1:0] base);
    logic [CW-1:0] d;
    d = n - base;
    if (n <= base) return '0;
    else if (d >= CW'(WORD_W)) return '1;
    else return ~({WORD_W{1'b1}} << d[WORD_LG-1:0]);
  endfunction

  logic [WORD_W-1:0] mem [0:DEPTH-1];
  logic [WORD_W-1:0] rd_data;

  logic [NUM_W-1:0]  num_blocks;
  logic [RSV_W-1:0]  reserved_blocks;
  logic [CMD_W-1:0]  cmd_hold;
  logic [BLK_W-1:0]  blk_hold;
  logic [PW-1:0]     ptr;
  logic              chk_valid;
  logic [AW-1:0]     chk_ptr;
  stat_t             res_status;
  logic [BLK_W-1:0]  res_block;

  logic [NUM_W-1:0]  lim;
  logic [NUM_W-1:0]  rsv_end;
  logic [NUM_W-1:0]  occ_end;
  logic [CW-1:0]     issue_base;
  logic [CW-1:0]     chk_base;
  logic [WORD_W-1:0] masked;
  logic [WORD_W-1:0] onehot;
  logic [WORD_LG-1:0] idx;
  logic [WORD_W-1:0] fmt_word;
  logic [AW-1:0]     blk_word;
  logic [WORD_W-1:0] bit_sel;
  logic              found;
  logic              take;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;

  // effective volume size and format boundary
  assign lim = (num_blocks > NUM_W'(CAP)) ? NUM_W'(CAP) : num_blocks;
  assign rsv_end = {1'b0, reserved_blocks} + NUM_W'(1);
  assign occ_end = (rsv_end < lim) ? rsv_end : lim;

  // scan word selection and first-fit search
  assign issue_base = CW'(ptr) << WORD_LG;
  assign chk_base = CW'(chk_ptr) << WORD_LG;
  assign masked = rd_data & low_mask(CW'(lim), chk_base);
  assign found = |masked;
  assign onehot = masked & (~masked + WORD_W'(1));
  assign take = ctl.scan && chk_valid && found;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (onehot[i]) idx = idx | WORD_LG'(i);
    end
  end

  // format word: blocks below the boundary occupied, the rest free
  assign fmt_word = ~low_mask(CW'(occ_end), issue_base);

  // single block update
  assign blk_word = AW'(blk_hold >> WORD_LG);
  assign bit_sel = WORD_W'(1) << blk_hold[WORD_LG-1:0];

  // status to controller
  assign flags.issue_ok = issue_base < CW'(lim);
  assign flags.chk_valid = chk_valid;
  assign flags.found = found;
  assign flags.in_range = {1'b0, blk_hold} < lim;
  assign flags.sweep_last = ptr[AW-1:0] == AW'(DEPTH - 1);

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (ctl.sweep_init) begin
      mem_we = 1'b1;
      mem_wa = ptr[AW-1:0];
      mem_wd = '1;
    end else if (ctl.sweep_fmt) begin
      mem_we = 1'b1;
      mem_wa = ptr[AW-1:0];
      mem_wd = fmt_word;
    end else if (take) begin
      mem_we = 1'b1;
      mem_wa = chk_ptr;
      mem_wd = rd_data & ~onehot;
    end else if (ctl.rmw_wr) begin
      mem_we = 1'b1;
      mem_wa = blk_word;
      mem_wd = (cmd_hold == CMD_FREE) ? (rd_data | bit_sel) : (rd_data & ~bit_sel);
    end
  end

  assign mem_re = (ctl.scan && flags.issue_ok) || ctl.rmw_rd;
  assign mem_ra = ctl.rmw_rd ? blk_word : ptr[AW-1:0];

  // bitmap memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_blocks      <= NUM_BLOCKS_RST;
      reserved_blocks <= RSV_BLOCKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_NUM_BLOCKS: num_blocks <= cfg_wdata;
        CFG_RESERVED:   reserved_blocks <= cfg_wdata[RSV_W-1:0];
        default: ;
      endcase
    end
  end

  // word pointer and scan pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      chk_valid <= 1'b0;
    end else if (ctl.load) begin
      ptr       <= '0;
      chk_valid <= 1'b0;
    end else if (ctl.sweep_init || ctl.sweep_fmt) begin
      ptr <= ptr + PW'(1);
    end else if (ctl.scan) begin
      chk_valid <= flags.issue_ok;
      if (flags.issue_ok) ptr <= ptr + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) chk_ptr <= ptr[AW-1:0];
  end

  // command hold and working result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_hold   <= cmd;
      blk_hold   <= block;
      res_status <= STAT_OK;
      res_block  <= '0;
    end else if (take) begin
      res_block <= BLK_W'({chk_ptr, idx});
    end else if (ctl.set_res) begin
      res_status <= ctl.res_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status          <= res_status;
      allocated_block <= res_block;
    end
  end

endmodule

`default_nettype wire

// File: bench/block_allocation_bitmap_tb.sv
`timescale 1ns / 1ps

module block_allocation_bitmap_tb;
  import bab_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int TRAFFIC_ITEMS = 195;

  typedef struct packed {
    stat_t                st;
    logic [BLK_W-1:0]     blk;
  } bitmap_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = CFG_NUM_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      cmd = CMD_ALLOC;
  logic [BLK_W-1:0]      block = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STAT_W-1:0]     status;
  logic [BLK_W-1:0]      allocated_block;

  // mirror of the volume: one bit per block, 1 = free
  logic [BLOCK_SPACE-1:0] free_bits = '1;
  logic [NUM_W-1:0]       vol_blocks = NUM_BLOCKS_RST;
  logic [RSV_W-1:0]       rsv_blocks = RSV_BLOCKS_RST;

  bitmap_reply_t expected_replies[$];
  int            mismatch_count = 0;
  int            reply_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 32;
  int            recv_idle_pct = 60;
  int            hold_request = 0;
  int            hold_left = 0;

  block_allocation_bitmap u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .block           (block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .allocated_block (allocated_block)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // usable volume size, capped by the block number space
  function automatic int volume_limit();
    int lim;
    lim = int'(vol_blocks);
    if (lim > MAX_BLOCKS_DEF) lim = MAX_BLOCKS_DEF;
    if (lim > BLOCK_SPACE) lim = BLOCK_SPACE;
    return lim;
  endfunction

  // apply one command to the mirror and return the reply it must produce
  function automatic bitmap_reply_t bitmap_apply(input cmd_t op, input logic [BLK_W-1:0] blk);
    bitmap_reply_t r;
    int lim;
    logic found;
    lim = volume_limit();
    r.st = STAT_OK;
    r.blk = '0;
    found = 1'b0;
    case (op)
      CMD_ALLOC: begin
        r.st = STAT_FULL;
        for (int i = 0; i < lim; i++) begin
          if (!found && free_bits[i]) begin
            found = 1'b1;
            free_bits[i] = 1'b0;
            r.st = STAT_OK;
            r.blk = i[BLK_W-1:0];
          end
        end
      end
      CMD_FREE, CMD_OCCUPY: begin
        if (int'(blk) < lim) free_bits[blk] = (op == CMD_FREE);
        else r.st = STAT_RANGE;
      end
      default: begin
        // format: all free, then block zero and the bitmap blocks taken
        free_bits = '1;
        if (lim > 0) free_bits[0] = 1'b0;
        for (int i = 1; i <= int'(rsv_blocks); i++) begin
          if (i < lim) free_bits[i] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // block number: mostly in range, some anywhere, some past the volume end
  function automatic logic [BLK_W-1:0] pick_block();
    int lim;
    int roll;
    lim = volume_limit();
    roll = $urandom_range(99);
    if (lim > 0 && roll < 75) return BLK_W'($urandom_range(lim - 1));
    if (roll < 88 || lim >= BLOCK_SPACE) return BLK_W'($urandom_range(BLOCK_SPACE - 1));
    return BLK_W'($urandom_range(BLOCK_SPACE - 1, lim));
  endfunction

  // one command beat, with a random gap in front of it
  task automatic send_item(input cmd_t op, input logic [BLK_W-1:0] blk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= op;
    block <= blk;
    do @(negedge clk); while (in_ready !== 1'b1);
    expected_replies.push_back(bitmap_apply(op, blk));
    @(posedge clk);
  endtask

  // let every reply come back and the block go quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both volume registers, block must be idle
  task automatic set_volume(input logic [NUM_W-1:0] n, input logic [RSV_W-1:0] r);
    logic pad;
    pad = 1'($urandom_range(1));
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_NUM_BLOCKS;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_addr <= CFG_RESERVED;
    cfg_wdata <= {pad, r};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vol_blocks = n;
    rsv_blocks = r;
  endtask

  // random volume size, weighted toward small volumes that fill up quickly
  task automatic pick_volume();
    int roll;
    int n;
    int r;
    roll = $urandom_range(99);
    if (roll < 60) n = $urandom_range(64, 1);
    else if (roll < 75) n = $urandom_range(4096, 65);
    else if (roll < 85) n = 4096;
    else if (roll < 90) n = 0;
    else n = $urandom_range(8191, 4097);
    if ($urandom_range(99) < 75) r = $urandom_range((n < 16) ? 8 : n / 2);
    else r = $urandom_range(4095);
    if (r > 4095) r = 4095;
    set_volume(NUM_W'(n), RSV_W'(r));
  endtask

  // mixed command stream, allocate-heavy so small volumes run full
  task automatic run_traffic(input int count);
    int roll;
    logic [BLK_W-1:0] b;
    repeat (count) begin
      roll = $urandom_range(99);
      b = pick_block();
      if (roll < 45) send_item(CMD_ALLOC, b);
      else if (roll < 75) send_item(CMD_FREE, b);
      else if (roll < 92) send_item(CMD_OCCUPY, b);
      else send_item(CMD_FORMAT, b);
    end
  endtask

  // state after reset: everything free, default volume
  task automatic test_power_on();
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '1);
    send_item(CMD_OCCUPY, 12'hFFF);
    send_item(CMD_FREE, 12'h000);
    send_item(CMD_ALLOC, 12'h5A5);
    send_item(CMD_FREE, 12'hFFF);
    send_item(CMD_FREE, 12'hFFF);
    send_item(CMD_OCCUPY, 12'h001);
  endtask

  // format, empty volume, oversize volume, reserved area past the end
  task automatic test_range_and_format();
    send_item(CMD_FORMAT, '0);
    send_item(CMD_ALLOC, '0);
    wait_idle();
    set_volume(13'd0, 12'd0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 12'h000);
    send_item(CMD_OCCUPY, 12'hFFF);
    send_item(CMD_FORMAT, '0);
    wait_idle();
    set_volume(13'h1FFF, 12'hFFF);
    send_item(CMD_FORMAT, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 12'hFFF);
    send_item(CMD_ALLOC, '0);
    wait_idle();
    set_volume(13'd1, 12'hFFF);
    send_item(CMD_FORMAT, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 12'h000);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 12'h001);
    wait_idle();
    set_volume(13'd4096, 12'd0);
    send_item(CMD_FORMAT, '0);
    send_item(CMD_ALLOC, '0);
  endtask

  // small volume: format, allocate past full, free a few, allocate again
  task automatic test_fill_to_full();
    int n;
    int r;
    wait_idle();
    n = $urandom_range(70, 9);
    r = $urandom_range(8);
    set_volume(NUM_W'(n), RSV_W'(r));
    send_item(CMD_FORMAT, pick_block());
    repeat (n - r + 1) send_item(CMD_ALLOC, pick_block());
    repeat (6) send_item(CMD_FREE, BLK_W'($urandom_range(n - 1)));
    repeat (8) send_item(CMD_ALLOC, pick_block());
  endtask

  // receiver holds off while commands keep coming, input must back up
  task automatic test_output_stall();
    wait_idle();
    send_idle_pct = 0;
    hold_request = 400;
    run_traffic(24);
    send_idle_pct = 32;
  endtask

  // random volumes under three idle patterns
  task automatic test_random_traffic();
    int idle_plan[3][2];
    idle_plan = '{'{32, 60}, '{60, 32}, '{0, 0}};
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = idle_plan[m][0];
      recv_idle_pct = idle_plan[m][1];
      for (int k = 0; k < 3; k++) begin
        wait_idle();
        pick_volume();
        run_traffic(TRAFFIC_ITEMS);
      end
    end
  endtask

  // receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // reply beat check, sampled at the falling edge before the accepting edge
  always @(negedge clk) begin
    bitmap_reply_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_replies.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected reply: status=%0d allocated_block=%0d", status, allocated_block);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.st || allocated_block !== want.blk) begin
          if (mismatch_count < 10)
            $display("reply %0d: expected status=%0d allocated_block=%0d, got %0d %0d",
                     reply_count, want.st, want.blk, status, allocated_block);
          mismatch_count++;
        end
      end
      reply_count++;
    end
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_power_on();
    test_range_and_format();
    test_fill_to_full();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
